// ----- hw/rtl/fssc_pkg.sv -----
// Package for the fan spin-up / spin-down supervisor.
// Holds the command, register-index and sequencer codes, constants and the state structs.
// No dependencies.
package fssc_pkg;

  typedef enum logic [1:0] {
    CMD_IDLE    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_RISE    = 2'd2,
    CMD_FALL    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SPINUP_EN  = 3'd0,
    REG_FAN0_DIV   = 3'd1,
    REG_FAN1_DIV   = 3'd2,
    REG_BOOST_THR  = 3'd3,
    REG_BOOST_DUTY = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } seq_state_t;

  localparam logic [20:0] SPEED_NUM      = 21'd1346000;
  localparam logic [13:0] SPEED_LO       = 14'd3400;
  localparam logic [13:0] SPEED_HI_P1    = 14'd10501;
  localparam logic [7:0]  PERIOD_BAD     = 8'd255;
  localparam logic [7:0]  PERIOD_A       = 8'd3;
  localparam logic [7:0]  PERIOD_B       = 8'd4;
  localparam logic [7:0]  STABLE_LO      = 8'd60;
  localparam logic [7:0]  STABLE_HI      = 8'd254;
  localparam logic [2:0]  BOOST_TICKS    = 3'd4;
  localparam logic [7:0]  ARM_DELAY      = 8'd250;
  localparam logic [7:0]  ARM_MIN        = 8'd1;
  localparam logic [7:0]  ARM_MAX        = 8'd5;
  localparam logic [5:0]  CHECK_COUNT    = 6'd45;
  localparam logic [3:0]  RESTORE_COUNT  = 4'd15;
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;
  localparam logic [7:0]  BOOST_THR_RST  = 8'd11;
  localparam logic [7:0]  BOOST_DUTY_RST = 8'd115;

  typedef struct packed {
    logic       spinup_en;
    logic [2:0] fan0_div;
    logic [2:0] fan1_div;
    logic [7:0] boost_thr;
    logic [7:0] boost_duty;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  boost_rem;
    logic [7:0]  watch_delay;
    logic [5:0]  unstable_cnt;
    logic [3:0]  stable_cnt;
    logic [7:0]  last_duty;
    logic [7:0]  prev_duty;
    logic [15:0] spindown_cnt;
  } fan_state_t;

  localparam int FAN_STATE_W = $bits(fan_state_t);

  typedef struct packed {
    logic        drive_valid;
    logic [7:0]  drive_duty;
    logic [7:0]  stored_duty;
    logic        spindown_now;
    logic [15:0] spindown_total;
    logic        boost_active;
  } result_t;

endpackage

// ----- hw/rtl/fssc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/fssc_update.sv -----
// Per-fan state update: boost countdown, watch delay, stability counters, spin-down.
// Depends on fssc_pkg.
module fssc_update #(
  parameter int NO_WATCH = 255
) (
  input  fssc_pkg::cmd_t       cmd,
  input  logic [7:0]           duty,
  input  logic [7:0]           period,
  input  logic                 spd_ok,
  input  fssc_pkg::cfg_t       cfg,
  input  fssc_pkg::fan_state_t st_cur,
  output fssc_pkg::fan_state_t st_nxt,
  output fssc_pkg::result_t    res
);
  import fssc_pkg::*;

  localparam logic [7:0] NO_WATCH_V = 8'(NO_WATCH);

  logic       stable;
  logic [7:0] arm_val;
  logic       dv;
  logic [7:0] dd;
  logic       sd;

  assign stable = (period == PERIOD_A) || (period == PERIOD_B) ||
                  ((period >= STABLE_LO) && (period <= STABLE_HI));
  assign arm_val = ((duty >= ARM_MIN) && (duty <= ARM_MAX)) ? ARM_DELAY : NO_WATCH_V;

  always_comb begin
    st_nxt = st_cur;
    dv     = 1'b0;
    dd     = '0;
    sd     = 1'b0;
    if (cmd == CMD_IDLE) begin
      if (st_cur.boost_rem != '0) begin
        // Any out-of-range speed restarts the run of good ticks.
        st_nxt.boost_rem = spd_ok ? (st_cur.boost_rem - 3'd1) : BOOST_TICKS;
        if (st_nxt.boost_rem == '0) begin
          dv = 1'b1;
          dd = st_cur.last_duty;
        end
      end else if (st_cur.watch_delay == '0) begin
        if (!stable) begin
          st_nxt.unstable_cnt = st_cur.unstable_cnt - 6'd1;
          st_nxt.stable_cnt   = RESTORE_COUNT;
          if (st_nxt.unstable_cnt == '0) begin
            dv                 = 1'b1;
            sd                 = 1'b1;
            st_nxt.prev_duty   = st_cur.last_duty;
            st_nxt.last_duty   = '0;
            st_nxt.watch_delay = NO_WATCH_V;
            if (st_cur.spindown_cnt != CNT_MAX) begin
              st_nxt.spindown_cnt = st_cur.spindown_cnt + 16'd1;
            end
          end
        end else if (st_cur.unstable_cnt != CHECK_COUNT) begin
          st_nxt.stable_cnt = st_cur.stable_cnt - 4'd1;
          if (st_nxt.stable_cnt == '0) begin
            st_nxt.unstable_cnt = CHECK_COUNT;
          end
        end
      end else if (st_cur.watch_delay < NO_WATCH_V) begin
        st_nxt.watch_delay = st_cur.watch_delay - 8'd1;
        if (st_nxt.watch_delay == '0) begin
          st_nxt.unstable_cnt = CHECK_COUNT;
        end
      end
    end else begin
      st_nxt.last_duty = duty;
      if ((cmd == CMD_RISE) && cfg.spinup_en && (duty < cfg.boost_thr)) begin
        dv               = 1'b1;
        dd               = cfg.boost_duty;
        st_nxt.boost_rem = BOOST_TICKS;
      end else begin
        if (cmd == CMD_RISE) begin
          dv = 1'b1;
          dd = duty;
        end
        st_nxt.watch_delay = arm_val;
        st_nxt.boost_rem   = '0;
      end
    end
  end

  always_comb begin
    res.drive_valid    = dv;
    res.drive_duty     = dd;
    res.stored_duty    = st_nxt.last_duty;
    res.spindown_now   = sd;
    res.spindown_total = st_nxt.spindown_cnt;
    res.boost_active   = (st_nxt.boost_rem != '0);
  end

endmodule

// ----- hw/rtl/fan_spinup_spindown_control.sv -----
// Top level of the fan spin-up / spin-down supervisor.
// Depends on fssc_pkg, fssc_ram and fssc_update.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall   command, fan, duty, period_ticks
//   out_     output     out_valid / out_stall drive and status fields, one per event
//   cfg_     input      cfg_valid / cfg_ready register index and write data
//
// For each event, the accept cycle reads the fan's entry from the state RAM, and the update
// cycle (ST_CALC) then updates it, writes it back and loads the output register.
// The RAM read is registered; the update cycle waits while a full output
// register is stalled, and a new event is taken while a finished word waits.
// The state RAM is not cleared by reset: a valid bit per fan makes an unwritten entry
// read as the reset state, so the block accepts events right after reset.
module fan_spinup_spindown_control #(
  parameter int FAN_COUNT = 2,
  parameter int NO_WATCH  = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_fan,
  input  logic [7:0]  in_duty,
  input  logic [7:0]  in_period_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drive_valid,
  output logic [7:0]  out_drive_duty,
  output logic [7:0]  out_stored_duty,
  output logic        out_spindown_now,
  output logic [15:0] out_spindown_total,
  output logic        out_boost_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import fssc_pkg::*;

  localparam int AW = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

  cfg_t             cfg_r;
  seq_state_t       state_r, state_nxt;
  logic             in_acc;
  logic             calc_go;
  logic [2:0]       shift;
  logic [14:0]      scaled;
  logic [28:0]      prod_lo, prod_hi;
  logic             spd_ok;
  cmd_t             cmd_r;
  logic [AW-1:0]    fan_r;
  logic             fan_ok_r;
  logic [7:0]       duty_r;
  logic [7:0]       period_r;
  logic             spd_ok_r;
  logic [FAN_COUNT-1:0] vld_r;
  logic             ram_we;
  logic [FAN_STATE_W-1:0] ram_rdata;
  fan_state_t       st_rst, st_cur, st_nxt;
  result_t          res;
  result_t          out_r;
  logic             out_valid_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spinup_en  <= 1'b0;
      cfg_r.fan0_div   <= '0;
      cfg_r.fan1_div   <= '0;
      cfg_r.boost_thr  <= BOOST_THR_RST;
      cfg_r.boost_duty <= BOOST_DUTY_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SPINUP_EN:  cfg_r.spinup_en  <= cfg_data[0];
        REG_FAN0_DIV:   cfg_r.fan0_div   <= cfg_data[2:0];
        REG_FAN1_DIV:   cfg_r.fan1_div   <= cfg_data[2:0];
        REG_BOOST_THR:  cfg_r.boost_thr  <= cfg_data;
        REG_BOOST_DUTY: cfg_r.boost_duty <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  assign in_acc  = in_valid && !in_stall;
  assign calc_go = (state_r == ST_CALC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CALC;
      ST_CALC: if (calc_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Speed range test without a divider: N / D in [LO, HI] iff LO*D <= N < (HI+1)*D.
  assign shift   = in_fan ? cfg_r.fan1_div : cfg_r.fan0_div;
  assign scaled  = 15'(in_period_ticks) << shift;
  assign prod_lo = 29'(scaled) * 29'(SPEED_LO);
  assign prod_hi = 29'(scaled) * 29'(SPEED_HI_P1);
  assign spd_ok  = (in_period_ticks != '0) && (in_period_ticks != PERIOD_BAD) &&
                   (29'(SPEED_NUM) >= prod_lo) && (29'(SPEED_NUM) < prod_hi);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= cmd_t'(in_command);
      fan_r    <= AW'(in_fan);
      fan_ok_r <= (int'(in_fan) < FAN_COUNT);
      duty_r   <= in_duty;
      period_r <= in_period_ticks;
      spd_ok_r <= spd_ok;
    end
  end

  // State memory with per-fan valid bits.
  assign ram_we = calc_go && fan_ok_r;

  fssc_ram #(
    .WIDTH (FAN_STATE_W),
    .DEPTH (FAN_COUNT),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fan_r),
    .wdata (st_nxt),
    .re    (in_acc),
    .raddr (AW'(in_fan)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[fan_r] <= 1'b1;
    end
  end

  always_comb begin
    st_rst              = '0;
    st_rst.watch_delay  = 8'(NO_WATCH);
    st_rst.unstable_cnt = CHECK_COUNT;
    st_rst.stable_cnt   = RESTORE_COUNT;
  end

  assign st_cur = vld_r[fan_r] ? fan_state_t'(ram_rdata) : st_rst;

  fssc_update #(
    .NO_WATCH (NO_WATCH)
  ) u_update (
    .cmd    (cmd_r),
    .duty   (duty_r),
    .period (period_r),
    .spd_ok (spd_ok_r),
    .cfg    (cfg_r),
    .st_cur (st_cur),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (calc_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      out_r <= fan_ok_r ? res : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_valid    = out_r.drive_valid;
  assign out_drive_duty     = out_r.drive_duty;
  assign out_stored_duty    = out_r.stored_duty;
  assign out_spindown_now   = out_r.spindown_now;
  assign out_spindown_total = out_r.spindown_total;
  assign out_boost_active   = out_r.boost_active;

endmodule

// ----- hw/rtl/fssc_checker.sv -----
// Port-level checker for the fan supervisor, bound to the top level.
// Depends only on the top level's ports.
module fssc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_command,
  input logic        in_fan,
  input logic [7:0]  in_duty,
  input logic [7:0]  in_period_ticks,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_drive_valid,
  input logic [7:0]  out_drive_duty,
  input logic [7:0]  out_stored_duty,
  input logic        out_spindown_now,
  input logic [15:0] out_spindown_total,
  input logic        out_boost_active,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [7:0]  cfg_data
);

  // An accepted word keeps the input side busy for its update cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted in the cycle after an accept");

  // A word without a drive carries a zero duty.
  a_idle_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drive_valid) |-> (out_drive_duty == 8'd0))
    else $error("drive duty nonzero without drive valid");

  // A spin-down drives zero, clears the stored duty and never happens during a boost.
  a_spindown_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_spindown_now) |-> (out_drive_valid && (out_drive_duty == 8'd0) &&
      (out_stored_duty == 8'd0) && !out_boost_active && (out_spindown_total != 16'd0)))
    else $error("inconsistent spin-down word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_drive_duty) &&
      $stable(out_stored_duty) && $stable(out_spindown_total)))
    else $error("stalled output word changed");

endmodule

bind fan_spinup_spindown_control fssc_checker u_fssc_checker (.*);

// ----- verif/fan_spinup_spindown_control_test.sv -----
// Self-checking testbench for the fan spin-up / spin-down supervisor.
// Drives events and register writes, predicts every result word and checks them in order.
// Depends on fssc_pkg and fan_spinup_spindown_control.
module fan_spinup_spindown_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fssc_pkg::*;

  localparam int unsigned RPM_SCALE   = 1346000;
  localparam int unsigned RPM_MIN     = 3400;
  localparam int unsigned RPM_MAX     = 10500;
  localparam logic [7:0]  WATCH_OFF   = 8'd255;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // Tracks both fans and the registers, and holds the words still owed by the block.
  class fan_duty_tracker;
    cfg_t        regs;
    fan_state_t  fans[2];
    result_t     pending_words[$];
    int unsigned fails;

    function new();
      regs = '{spinup_en: 1'b0, fan0_div: 3'd0, fan1_div: 3'd0,
               boost_thr: 8'd11, boost_duty: 8'd115};
      foreach (fans[i]) begin
        fans[i] = '{boost_rem: 3'd0, watch_delay: WATCH_OFF, unstable_cnt: CHECK_COUNT,
                    stable_cnt: RESTORE_COUNT, last_duty: 8'd0, prev_duty: 8'd0,
                    spindown_cnt: 16'd0};
      end
      fails = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [7:0] data);
      case (idx)
        REG_SPINUP_EN:  regs.spinup_en  = data[0];
        REG_FAN0_DIV:   regs.fan0_div   = data[2:0];
        REG_FAN1_DIV:   regs.fan1_div   = data[2:0];
        REG_BOOST_THR:  regs.boost_thr  = data;
        REG_BOOST_DUTY: regs.boost_duty = data;
        default: ;
      endcase
    endfunction

    function bit speed_in_range(logic [7:0] period, logic [2:0] shift);
      int unsigned rpm;
      if (period == 8'd0 || period == 8'hFF) return 1'b0;
      rpm = RPM_SCALE / ({24'd0, period} << shift);
      return rpm >= RPM_MIN && rpm <= RPM_MAX;
    endfunction

    function bit period_steady(logic [7:0] period);
      return period == 8'd3 || period == 8'd4 || (period >= 8'd60 && period <= 8'd254);
    endfunction

    function void note_event(cmd_t cmd, logic fan, logic [7:0] duty, logic [7:0] period);
      fan_state_t s;
      result_t    r;
      s = fans[fan];
      r = '0;
      if (cmd == CMD_IDLE) begin
        if (s.boost_rem != 3'd0) begin
          if (speed_in_range(period, fan ? regs.fan1_div : regs.fan0_div))
            s.boost_rem = s.boost_rem - 3'd1;
          else
            s.boost_rem = BOOST_TICKS;
          if (s.boost_rem == 3'd0) begin
            r.drive_valid = 1'b1;
            r.drive_duty  = s.last_duty;
          end
        end else if (s.watch_delay == 8'd0) begin
          if (!period_steady(period)) begin
            s.unstable_cnt = s.unstable_cnt - 6'd1;
            s.stable_cnt   = RESTORE_COUNT;
            if (s.unstable_cnt == 6'd0) begin
              r.drive_valid  = 1'b1;
              r.drive_duty   = 8'd0;
              s.prev_duty    = s.last_duty;
              s.last_duty    = 8'd0;
              s.watch_delay  = WATCH_OFF;
              if (s.spindown_cnt != 16'hFFFF) s.spindown_cnt = s.spindown_cnt + 16'd1;
              r.spindown_now = 1'b1;
            end
          end else if (s.unstable_cnt != CHECK_COUNT) begin
            s.stable_cnt = s.stable_cnt - 4'd1;
            if (s.stable_cnt == 4'd0) s.unstable_cnt = CHECK_COUNT;
          end
        end else if (s.watch_delay < WATCH_OFF) begin
          s.watch_delay = s.watch_delay - 8'd1;
          if (s.watch_delay == 8'd0) s.unstable_cnt = CHECK_COUNT;
        end
      end else begin
        s.last_duty = duty;
        if (cmd == CMD_RISE && regs.spinup_en && duty < regs.boost_thr) begin
          r.drive_valid = 1'b1;
          r.drive_duty  = regs.boost_duty;
          s.boost_rem   = BOOST_TICKS;
        end else begin
          if (cmd == CMD_RISE) begin
            r.drive_valid = 1'b1;
            r.drive_duty  = duty;
          end
          s.watch_delay = (duty >= 8'd1 && duty <= 8'd5) ? ARM_DELAY : WATCH_OFF;
          s.boost_rem   = 3'd0;
        end
      end
      r.stored_duty    = s.last_duty;
      r.spindown_total = s.spindown_cnt;
      r.boost_active   = s.boost_rem != 3'd0;
      fans[fan] = s;
      pending_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        fails++;
      end
    endfunction

    function void check_word(result_t seen);
      result_t want;
      if (pending_words.size() == 0) begin
        $error("result word arrived with no event outstanding");
        fails++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("drive_valid", 16'(want.drive_valid), 16'(seen.drive_valid));
      compare_field("drive_duty", 16'(want.drive_duty), 16'(seen.drive_duty));
      compare_field("stored_duty", 16'(want.stored_duty), 16'(seen.stored_duty));
      compare_field("spindown_now", 16'(want.spindown_now), 16'(seen.spindown_now));
      compare_field("spindown_total", want.spindown_total, seen.spindown_total);
      compare_field("boost_active", 16'(want.boost_active), 16'(seen.boost_active));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_IDLE;
  logic        in_fan = 1'b0;
  logic [7:0]  in_duty = 8'd0;
  logic [7:0]  in_period_ticks = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_drive_valid;
  logic [7:0]  out_drive_duty;
  logic [7:0]  out_stored_duty;
  logic        out_spindown_now;
  logic [15:0] out_spindown_total;
  logic        out_boost_active;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_SPINUP_EN;
  logic [7:0]  cfg_data = 8'd0;

  fan_duty_tracker tracker = new();
  int unsigned     sent_words = 0;
  int unsigned     burst_left = 0;
  int unsigned     stall_left = 0;
  int unsigned     stall_mode = 0;
  int unsigned     cycle_count = 0;

  fan_spinup_spindown_control u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_fan             (in_fan),
    .in_duty            (in_duty),
    .in_period_ticks    (in_period_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_valid    (out_drive_valid),
    .out_drive_duty     (out_drive_duty),
    .out_stored_duty    (out_stored_duty),
    .out_spindown_now   (out_spindown_now),
    .out_spindown_total (out_spindown_total),
    .out_boost_active   (out_boost_active),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_word({out_drive_valid, out_drive_duty, out_stored_duty,
                          out_spindown_now, out_spindown_total, out_boost_active});
  end

  // The receiver changes its stall habit at random, from never stalling to almost always.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_event(cmd_t cmd, logic fan, logic [7:0] duty, logic [7:0] period);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_fan          <= fan;
    in_duty         <= duty;
    in_period_ticks <= period;
    do @(posedge clk); while (in_stall);
    tracker.note_event(cmd, fan, duty, period);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic wait_all_words();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic en, logic [2:0] div0, logic [2:0] div1,
                                logic [7:0] thr, logic [7:0] boost);
    wait_all_words();
    cfg_write(REG_SPINUP_EN, {7'd0, en});
    cfg_write(REG_FAN0_DIV, {5'd0, div0});
    cfg_write(REG_FAN1_DIV, {5'd0, div1});
    cfg_write(REG_BOOST_THR, thr);
    cfg_write(REG_BOOST_DUTY, boost);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_duty();
    logic [7:0] thr;
    thr = tracker.regs.boost_thr;
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(1, 5));
      1: return (thr != 8'd0) ? 8'($urandom_range(0, thr - 1)) : 8'd0;
      2: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Speed is within limits exactly when the shifted period lies in 129..395.
  function automatic logic [7:0] in_range_period(logic fan);
    logic [2:0]  shift;
    int unsigned lo;
    int unsigned hi;
    shift = fan ? tracker.regs.fan1_div : tracker.regs.fan0_div;
    lo = (129 + (1 << shift) - 1) >> shift;
    hi = 395 >> shift;
    if (hi > 254) hi = 254;
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic logic [7:0] steady_period();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 4)) : 8'($urandom_range(60, 254));
  endfunction

  function automatic logic [7:0] unsteady_period();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) : 8'd255;
      default: return 8'($urandom_range(5, 59));
    endcase
  endfunction

  task automatic noise_event(logic fan);
    cmd_t cmd;
    cmd = ($urandom_range(0, 1) == 0) ? CMD_IDLE : cmd_t'($urandom_range(1, 3));
    push_event(cmd, fan, pick_duty(), 8'($urandom_range(0, 255)));
  endtask

  // A rise into the boost range followed by idle ticks, mostly at a good speed.
  task automatic boost_run(logic fan);
    logic [7:0]  thr;
    logic [7:0]  duty;
    int unsigned ticks;
    thr = tracker.regs.boost_thr;
    duty = (thr != 8'd0) ? 8'($urandom_range(0, thr - 1)) : 8'($urandom_range(0, 255));
    push_event(CMD_RISE, fan, duty, 8'($urandom_range(0, 255)));
    ticks = $urandom_range(3, 9);
    repeat (ticks) begin
      if ($urandom_range(0, 6) == 0) noise_event(~fan);
      if ($urandom_range(0, 19) == 0)
        push_event(cmd_t'($urandom_range(1, 3)), fan, pick_duty(), 8'($urandom_range(0, 255)));
      push_event(CMD_IDLE, fan, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 4) != 0) ? in_range_period(fan)
                                             : 8'($urandom_range(0, 255)));
    end
  endtask

  // Arm the watch with a very low duty, wait out the delay, then feed unsteady periods.
  task automatic spindown_run(logic fan, bit with_recovery);
    push_event(($urandom_range(0, 1) == 0) ? CMD_RESTART : CMD_FALL, fan,
               8'($urandom_range(1, 5)), 8'($urandom_range(0, 255)));
    repeat (ARM_DELAY) begin
      if ($urandom_range(0, 9) == 0) noise_event(~fan);
      push_event(CMD_IDLE, fan, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < 70; i++) begin
      if (i == 20 && with_recovery)
        repeat (16) push_event(CMD_IDLE, fan, 8'($urandom_range(0, 255)), steady_period());
      push_event(CMD_IDLE, fan, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 19) == 0) ? steady_period() : unsteady_period());
    end
  endtask

  task automatic random_phase(int unsigned budget, bit with_watch);
    int unsigned stop_at;
    stop_at = sent_words + budget;
    if (with_watch) spindown_run(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    while (sent_words < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: boost_run(1'($urandom_range(0, 1)));
        4: begin
          if ($urandom_range(0, 3) == 0) wait_all_words();
          else noise_event(1'($urandom_range(0, 1)));
        end
        default: repeat ($urandom_range(1, 6)) noise_event(1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: no boost, so rises drive their duty; low duties arm the watch and higher ones disarm it.
    push_event(CMD_IDLE, 1'b0, 8'd255, 8'd0);
    push_event(CMD_IDLE, 1'b1, 8'd0, 8'd255);
    push_event(CMD_RISE, 1'b0, 8'd0, 8'd0);
    push_event(CMD_RISE, 1'b1, 8'd255, 8'd255);
    push_event(CMD_FALL, 1'b0, 8'd1, 8'd0);
    push_event(CMD_RESTART, 1'b1, 8'd5, 8'd0);
    push_event(CMD_IDLE, 1'b0, 8'd0, 8'd3);
    push_event(CMD_RESTART, 1'b1, 8'd6, 8'd4);
    push_event(CMD_FALL, 1'b0, 8'd255, 8'd60);
    push_event(CMD_IDLE, 1'b1, 8'd0, 8'd254);
    push_event(CMD_IDLE, 1'b0, 8'd0, 8'd59);

    apply_settings(1'b1, 3'd0, 3'd7, 8'd11, 8'd115);
    // Boost on fan 0: unmeasurable periods and a speed just too high restart the count.
    push_event(CMD_RISE, 1'b0, 8'd0, 8'd0);
    push_event(CMD_IDLE, 1'b0, 8'd0, 8'd255);
    push_event(CMD_IDLE, 1'b0, 8'd0, 8'd0);
    push_event(CMD_IDLE, 1'b0, 8'd0, 8'd129);
    push_event(CMD_IDLE, 1'b0, 8'd0, 8'd128);
    repeat (4) push_event(CMD_IDLE, 1'b0, 8'd0, 8'd254);
    push_event(CMD_RISE, 1'b0, 8'd10, 8'd0);
    push_event(CMD_RISE, 1'b0, 8'd11, 8'd0);
    // Fan 1 with the largest shift.
    push_event(CMD_RISE, 1'b1, 8'd3, 8'd0);
    repeat (2) begin
      push_event(CMD_IDLE, 1'b1, 8'd0, 8'd2);
      push_event(CMD_IDLE, 1'b1, 8'd0, 8'd3);
    end

    random_phase(450, 1'b1);
    apply_settings(1'b1, 3'd3, 3'd1, 8'd255, 8'd255);
    random_phase(220, 1'b0);
    apply_settings(1'b0, 3'd7, 3'd0, 8'd0, 8'd0);
    random_phase(220, 1'b0);
    apply_settings(1'b1, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_phase(450, 1'b1);

    wait_all_words();
    repeat (8) @(negedge clk);
    if (tracker.fails == 0 && tracker.pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
